FILE: rtl/core/kset_pkg.sv
// ----------------------------------------------------------------------------
// Keyed sorted event table: shared definitions
// Operation and status codes, the stored entry layout and the scan result.
// ----------------------------------------------------------------------------
`default_nettype none

package kset_pkg;

    // Operation codes. Any other code reads the head without changing the table.
    localparam logic [1:0] FUNC_UPSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    localparam int unsigned KEY_W  = 64;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned ACT_W  = 2;

    // One stored event, as it sits in a single memory word.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
        logic [ACT_W-1:0]  act;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // Outcome of comparing one stored entry against the word being processed.
    typedef struct packed {
        logic match;   // first entry carrying the searched key
        logic ahead;   // entry lands ahead of the new or updated entry
    } scan_t;

endpackage

`default_nettype wire

FILE: rtl/core/keyed_sorted_event_table.sv
// ----------------------------------------------------------------------------
// Keyed sorted event table
// Bounded table of timed events kept in timestamp order, with keyed update.
// ----------------------------------------------------------------------------
// Usage. Each input word carries an operation (upsert, delete by key, or any
// other code to read the head), a 64-bit key, a timestamp and an action code.
// Every input word produces exactly one output word: a status, the earliest
// entry of the table and the number of entries after the operation.
// Timing. The block takes one word at a time; in_ready is high only while the
// sequencer is idle. An upsert or delete scans the valid entries once, one
// memory read per cycle, then moves entries one slot per cycle to open or
// close a gap; an upsert that fits then writes its entry into its final slot.
// Each operation ends by reading slot zero for the head.
// Stalls. The result sits in an output register, so a new word is accepted
// while the previous result waits; a finished operation holds in its last
// step until the output register is free.
// Reset. rst_n clears the entry count and the sequencer; the entry memory is
// not cleared, as only slots below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_sorted_event_table #(
    parameter int unsigned ENTRIES = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         func,
    input  wire logic [kset_pkg::KEY_W-1:0]         key,
    input  wire logic [kset_pkg::TIME_W-1:0]        timestamp,
    input  wire logic [kset_pkg::ACT_W-1:0]         action,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              status,
    output logic [kset_pkg::KEY_W-1:0]              head_key,
    output logic [kset_pkg::TIME_W-1:0]             head_timestamp,
    output logic [kset_pkg::ACT_W-1:0]              head_action,
    output logic [5:0]                              entry_count
);

    // Slot index width and count width (the count must reach ENTRIES itself).
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_PUT      = 3'd4;
    localparam logic [2:0] S_HEAD_RD  = 3'd5;
    localparam logic [2:0] S_HEAD_OUT = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  slot_reg, slot_next;
    logic                           found_reg, found_next;
    logic [AW-1:0]                  scan_idx_reg, scan_idx_next;
    logic [AW-1:0]                  mv_cur_reg, mv_cur_next;
    logic [AW-1:0]                  mv_end_reg, mv_end_next;
    logic                           mv_up_reg, mv_up_next;
    logic [1:0]                     status_reg, status_next;

    // The word being processed.
    logic [1:0]                     func_reg;
    logic [kset_pkg::KEY_W-1:0]     key_reg;
    logic [kset_pkg::TIME_W-1:0]    stamp_reg;
    logic [kset_pkg::ACT_W-1:0]     act_reg;
    logic                           load_op;

    // Output register.
    logic                           out_valid_reg;
    logic                           out_load;
    logic [1:0]                     out_status_reg;
    kset_pkg::entry_t               out_head_reg;
    logic [5:0]                     out_count_reg;

    // Memory ports.
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [AW-1:0]                  ram_raddr;
    kset_pkg::entry_t               ram_wdata;
    kset_pkg::entry_t               ram_rdata;
    logic [kset_pkg::ENTRY_W-1:0]   ram_rword;

    kset_pkg::entry_t               op_entry;
    kset_pkg::scan_t                scan_res;
    logic [CW-1:0]                  slot_eff;
    logic                           scan_last;

    assign ram_rdata = kset_pkg::entry_t'(ram_rword);

    // All three fields of an entry share one memory word.
    kset_ram #(
        .WIDTH (kset_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rword)
    );

    // Compares each entry read during the scan against the word in hand.
    kset_cmp u_cmp (
        .ent   (ram_rdata),
        .key   (key_reg),
        .stamp (stamp_reg),
        .found (found_reg),
        .res   (scan_res)
    );

    always_comb
    begin
        op_entry.key   = key_reg;
        op_entry.stamp = stamp_reg;
        op_entry.act   = act_reg;
    end

    // A new key is placed as if it sat just behind the last valid entry.
    assign slot_eff  = found_reg ? slot_reg : count_reg;
    assign scan_last = (CW'(scan_idx_reg) == count_reg - 1'b1);

    // ------------------------------------------------------------------------
    // Sequencer. The scan counts the entries that stay ahead of the word in
    // hand, which gives its final slot directly: the table is always sorted,
    // so an upsert only has to move the entries between the old and the new
    // slot by one place, and a delete closes the gap behind the removed slot.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        slot_next     = slot_reg;
        found_next    = found_reg;
        scan_idx_next = scan_idx_reg;
        mv_cur_next   = mv_cur_reg;
        mv_end_next   = mv_end_reg;
        mv_up_next    = mv_up_reg;
        status_next   = status_reg;
        ram_raddr     = '0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = op_entry;
        load_op       = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    load_op       = 1'b1;
                    found_next    = 1'b0;
                    pos_next      = '0;
                    scan_idx_next = '0;
                    // Slot zero is read now and appears at the first scan step.
                    if ((func == kset_pkg::FUNC_UPSERT || func == kset_pkg::FUNC_DELETE)
                        && count_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_res.match)
                begin
                    found_next = 1'b1;
                    slot_next  = CW'(scan_idx_reg);
                end
                if (scan_res.ahead)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                if (scan_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    scan_idx_next = AW'(scan_idx_reg + 1'b1);
                    ram_raddr     = AW'(scan_idx_reg + 1'b1);
                end
            end

            S_DECIDE:
            begin
                status_next = kset_pkg::STATUS_OK;
                state_next  = S_HEAD_RD;
                case (func_reg)
                    kset_pkg::FUNC_UPSERT:
                    begin
                        if (!found_reg && count_reg == CW'(ENTRIES))
                        begin
                            status_next = kset_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            if (!found_reg)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            if (pos_reg < slot_eff)
                            begin
                                // Entries from the new slot up to just below the old
                                // one move one place towards the tail.
                                mv_up_next  = 1'b1;
                                mv_cur_next = AW'(slot_eff - 1'b1);
                                mv_end_next = AW'(pos_reg);
                                ram_raddr   = AW'(slot_eff - 1'b1);
                                state_next  = S_SHIFT;
                            end
                            else if (pos_reg > slot_eff)
                            begin
                                mv_up_next  = 1'b0;
                                mv_cur_next = AW'(slot_eff + 1'b1);
                                mv_end_next = AW'(pos_reg);
                                ram_raddr   = AW'(slot_eff + 1'b1);
                                state_next  = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                    end

                    kset_pkg::FUNC_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = kset_pkg::STATUS_NOT_FOUND;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            if (slot_reg + 1'b1 < count_reg)
                            begin
                                mv_up_next  = 1'b0;
                                mv_cur_next = AW'(slot_reg + 1'b1);
                                mv_end_next = AW'(count_reg - 1'b1);
                                ram_raddr   = AW'(slot_reg + 1'b1);
                                state_next  = S_SHIFT;
                            end
                        end
                    end

                    default:
                    begin
                        status_next = (count_reg != '0) ? kset_pkg::STATUS_OK
                                                        : kset_pkg::STATUS_EMPTY;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // The entry read last cycle is written one slot along while
                // the next one is read; the two addresses never coincide.
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ram_waddr = mv_up_reg ? AW'(mv_cur_reg + 1'b1) : AW'(mv_cur_reg - 1'b1);
                if (mv_cur_reg == mv_end_reg)
                begin
                    state_next = (func_reg == kset_pkg::FUNC_UPSERT) ? S_PUT : S_HEAD_RD;
                end
                else
                begin
                    mv_cur_next = mv_up_reg ? AW'(mv_cur_reg - 1'b1) : AW'(mv_cur_reg + 1'b1);
                    ram_raddr   = mv_cur_next;
                end
            end

            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(pos_reg);
                state_next = S_HEAD_RD;
            end

            S_HEAD_RD:
            begin
                state_next = S_HEAD_OUT;
            end

            S_HEAD_OUT:
            begin
                // The read address stays at slot zero, so the head holds here.
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            slot_reg      <= '0;
            found_reg     <= 1'b0;
            scan_idx_reg  <= '0;
            mv_cur_reg    <= '0;
            mv_end_reg    <= '0;
            mv_up_reg     <= 1'b0;
            status_reg    <= kset_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            found_reg     <= found_next;
            scan_idx_reg  <= scan_idx_next;
            mv_cur_reg    <= mv_cur_next;
            mv_end_reg    <= mv_end_next;
            mv_up_reg     <= mv_up_next;
            status_reg    <= status_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (load_op)
        begin
            func_reg  <= func;
            key_reg   <= key;
            stamp_reg <= timestamp;
            act_reg   <= action;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_head_reg   <= (count_reg != '0) ? ram_rdata : '0;
            out_count_reg  <= 6'(count_reg);
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign head_key       = out_head_reg.key;
    assign head_timestamp = out_head_reg.stamp;
    assign head_action    = out_head_reg.act;
    assign entry_count    = out_count_reg;

`ifndef SYNTHESIS
    // The count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(ENTRIES))
        else $error("entry count above table size");

    // The count only changes as the operation is decided.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_DECIDE))
        else $error("entry count changed outside the decide step");

    // Every memory write lands inside the valid region of the new count.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CW'(ram_waddr) < count_reg))
        else $error("memory write beyond the valid entries");

    // A dropped upsert is only reported with a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == kset_pkg::STATUS_FULL)
            |-> (out_count_reg == 6'(ENTRIES)))
        else $error("full status with spare room");

    // An empty status always comes with a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == kset_pkg::STATUS_EMPTY)
            |-> (out_count_reg == 6'd0))
        else $error("empty status with entries held");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/kset_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kset_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/kset_cmp.sv
// ----------------------------------------------------------------------------
// Keyed sorted event table: scan comparator
// Key match and sort-position compare, shared by every step of the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module kset_cmp (
    input  wire kset_pkg::entry_t                   ent,
    input  wire logic [kset_pkg::KEY_W-1:0]         key,
    input  wire logic [kset_pkg::TIME_W-1:0]        stamp,
    input  wire logic                               found,
    output kset_pkg::scan_t                         res
);

    logic key_eq;
    logic le;
    logic lt;

    assign key_eq = (ent.key == key);
    assign le     = (ent.stamp <= stamp);
    assign lt     = (ent.stamp < stamp);

    // Entries ahead of the matching slot keep their place on equal times;
    // entries behind it yield to the updated entry on equal times.
    always_comb
    begin
        res.match = key_eq && !found;
        res.ahead = !res.match && (found ? lt : le);
    end

endmodule

`default_nettype wire
